/* hw/rtl/tmhq_pkg.sv */
// Package for the timer min-heap queue: action and status codes, the controller
// state type and the control/status structs shared by controller and datapath.
// No dependencies.
package tmhq_pkg;

  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned TimeW = 64;

  typedef enum logic [2:0] {
    ACT_SCHEDULE = 3'd0,
    ACT_CANCEL   = 3'd1,
    ACT_QUERY    = 3'd2,
    ACT_EXPIRE   = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_RANGE    = 3'd2,
    ST_INACTIVE = 3'd3,
    ST_NONE_DUE = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,        // link sweep of the id table after reset
    S_DECODE,
    S_SCHED_RD,    // read the new id's free-list link
    S_SCHED_WT,
    S_LOOK_RD,     // read slot of id
    S_LOOK_WT,
    S_LOOK_RD2,    // read heap entry at that slot
    S_LOOK_WT2,
    S_ROOT_RD,     // expire/clear: read root
    S_ROOT_WT,
    S_RM_START,    // remove entry at cur: free id, read last entry
    S_RM_WT,
    S_RM_PAR_RD,   // read hole's parent
    S_RM_PAR_WT,
    S_UP_RD,       // sift up: read parent
    S_UP_WT,
    S_DN_RD,       // sift down: read both children
    S_DN_WT,
    S_PLACE,       // final write of the moving entry
    S_EMIT,
    S_HOLD         // emit removed entry once the next root is read
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;      // latch input beat
    logic init_wr;      // write link during init sweep
    logic rd_link;      // read slot_of_id[req id]
    logic rd_at_cur;    // read heap[cur]
    logic rd_last;      // read heap[count-1]
    logic rd_parent;    // read heap[parent(cur)]
    logic rd_children;  // read heap[2cur+1], heap[2cur+2]
    logic sched_take;   // pop free list, set up moving entry
    logic rm_take;      // free owner of heap[cur], move last entry into hole
    logic move_parent;  // heap[cur] <= parent, cur <= parent
    logic move_child;   // heap[cur] <= smaller child, cur <= child
    logic place;        // heap[cur] <= moving entry
    logic cnt_inc;
    logic set_cur_link; // cur <= read link
    logic set_cur_root; // cur <= 0
    logic [2:0] st;     // status of result
    logic res_from_rd;  // result id/time from removed entry
    logic res_from_look;// result id/time from heap read (query)
    logic res_id_only;  // id echoed, time 0
    logic res_sched;    // id and time of scheduled entry
    logic res_last;
    logic out_load;
  } tmhq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] action;
    logic       free_full;
    logic       id_range;
    logic       id_live;
    logic       empty;
    logic       root_due;
    logic       init_done;
    logic       cur_zero;
    logic       moved_lt_parent;
    logic       hole_valid;     // cur < count after remove
    logic       has_child;
    logic       child_lt;       // smaller child < moving time
    logic       out_busy;
  } tmhq_sts_t;

endpackage

/* hw/rtl/timer_min_heap_queue_unit.sv */
// Top level of the timer min-heap queue: controller and datapath.
// Depends on tmhq_pkg, tmhq_ctrl, tmhq_dp.
//
// channel   dir  tdata (low bit up)                               tuser
// s_axis    in   action[2:0] due_time[63:0] timer_id[7:0] now[63:0] -
// m_axis    out  status[2:0] timer_id_out[5:0] time_value[63:0]
//                active_count[6:0]                                 -   tlast = last
//
// One item at a time; each heap level is a registered memory read, then a
// compare and move. Clear-all repeats the removal per entry.
// After reset the id link table is swept before s_axis_tready is raised.
// A stalled result beat holds the controller until it is taken.
module timer_min_heap_queue_unit #(
  parameter int unsigned CAPACITY = tmhq_pkg::CapacityDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // action, due_time, timer_id, now, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // status, timer_id_out, time_value, active_count
  output logic         m_axis_tlast
);
  import tmhq_pkg::*;

  tmhq_cmd_t cmd;
  tmhq_sts_t sts;
  logic [2:0]  st;
  logic [5:0]  tid;
  logic [63:0] tv;
  logic [6:0]  ac;

  tmhq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .sts(sts), .cmd(cmd)
  );

  tmhq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst(rst),
    .in_action(s_axis_tdata[2:0]), .in_due_time(s_axis_tdata[66:3]),
    .in_timer_id(s_axis_tdata[74:67]), .in_now(s_axis_tdata[138:75]),
    .cmd(cmd), .sts(sts),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_status(st), .out_timer_id(tid), .out_time_value(tv),
    .out_active_count(ac), .out_last(m_axis_tlast)
  );

  // Pack result beat
  assign m_axis_tdata = {ac, tv, tid, st};
endmodule

/* hw/rtl/tmhq_ctrl.sv */
// Controller state machine of the timer min-heap queue.
// Depends on tmhq_pkg.
module tmhq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tmhq_pkg::tmhq_sts_t  sts,
  output tmhq_pkg::tmhq_cmd_t  cmd
);
  import tmhq_pkg::*;

  state_t state, state_next;
  logic   rm_mode, rm_mode_next; // 1: expire loop, 0: clear loop
  logic   in_rm, in_rm_next;     // sift belongs to a removal
  logic   from_cancel, from_cancel_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      rm_mode <= 1'b0;
      in_rm <= 1'b0;
      from_cancel <= 1'b0;
    end else begin
      state <= state_next;
      rm_mode <= rm_mode_next;
      in_rm <= in_rm_next;
      from_cancel <= from_cancel_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    rm_mode_next = rm_mode;
    in_rm_next = in_rm;
    from_cancel_next = from_cancel;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        in_rm_next = 1'b0;
        from_cancel_next = 1'b0;
        unique case (sts.action) inside
          ACT_SCHEDULE: begin
            if (sts.free_full) begin
              cmd.st = ST_FULL;
              state_next = S_EMIT;
            end else begin
              cmd.rd_link = 1'b1;
              state_next = S_SCHED_RD;
            end
          end
          ACT_CANCEL, ACT_QUERY: begin
            if (sts.id_range) begin
              cmd.st = ST_RANGE;
              state_next = S_EMIT;
            end else if (!sts.id_live) begin
              cmd.st = ST_INACTIVE;
              cmd.res_id_only = 1'b1;
              state_next = S_EMIT;
            end else begin
              cmd.rd_link = 1'b1;
              state_next = S_LOOK_RD;
            end
          end
          ACT_EXPIRE: begin
            rm_mode_next = 1'b1;
            if (sts.empty) begin
              cmd.st = ST_NONE_DUE;
              state_next = S_EMIT;
            end else begin
              cmd.set_cur_root = 1'b1;
              state_next = S_ROOT_RD;
            end
          end
          ACT_CLEAR: begin
            rm_mode_next = 1'b0;
            if (sts.empty) state_next = S_EMIT;
            else begin
              cmd.set_cur_root = 1'b1;
              state_next = S_ROOT_RD;
            end
          end
          default: state_next = S_EMIT;
        endcase
      end
      S_SCHED_RD: state_next = S_SCHED_WT;
      S_SCHED_WT: begin
        cmd.sched_take = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.res_sched = 1'b1;
        state_next = S_UP_RD;
      end
      S_LOOK_RD: state_next = S_LOOK_WT;
      S_LOOK_WT: begin
        cmd.set_cur_link = 1'b1;
        state_next = S_LOOK_RD2;
      end
      S_LOOK_RD2: begin
        cmd.rd_at_cur = 1'b1;
        state_next = S_LOOK_WT2;
      end
      S_LOOK_WT2: begin
        if (sts.action == ACT_QUERY) begin
          cmd.res_from_look = 1'b1;
          state_next = S_EMIT;
        end else begin
          from_cancel_next = 1'b1;
          state_next = S_RM_START;
        end
      end
      S_ROOT_RD: begin
        cmd.rd_at_cur = 1'b1;
        state_next = S_ROOT_WT;
      end
      S_ROOT_WT: begin
        if (rm_mode && !sts.root_due) begin
          // only reached on the first pass: not due at all
          cmd.st = ST_NONE_DUE;
          state_next = S_EMIT;
        end else state_next = S_RM_START;
      end
      S_RM_START: begin
        cmd.rd_last = 1'b1;
        state_next = S_RM_WT;
      end
      S_RM_WT: begin
        cmd.rm_take = 1'b1;
        in_rm_next = 1'b1;
        if (from_cancel || rm_mode) cmd.res_from_rd = 1'b1;
        state_next = sts.hole_valid ? S_RM_PAR_RD : S_EMIT;
      end
      S_RM_PAR_RD: begin
        cmd.rd_parent = 1'b1;
        state_next = S_RM_PAR_WT;
      end
      S_RM_PAR_WT: begin
        if (!sts.cur_zero && sts.moved_lt_parent) state_next = S_UP_RD;
        else state_next = S_DN_RD;
      end
      S_UP_RD: begin
        if (sts.cur_zero) state_next = S_PLACE;
        else begin
          cmd.rd_parent = 1'b1;
          state_next = S_UP_WT;
        end
      end
      S_UP_WT: begin
        if (sts.moved_lt_parent) begin
          cmd.move_parent = 1'b1;
          state_next = S_UP_RD;
        end else state_next = S_PLACE;
      end
      S_DN_RD: begin
        if (!sts.has_child) state_next = S_PLACE;
        else begin
          cmd.rd_children = 1'b1;
          state_next = S_DN_WT;
        end
      end
      S_DN_WT: begin
        if (sts.child_lt) begin
          cmd.move_child = 1'b1;
          state_next = S_DN_RD;
        end else state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // expire/clear with more to remove: loop without a beat for clear
        if (in_rm && !from_cancel && !rm_mode && !sts.empty) begin
          cmd.set_cur_root = 1'b1;
          in_rm_next = 1'b0;
          state_next = S_ROOT_RD;
        end else if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.res_last = 1'b1;
          if (in_rm && !from_cancel && rm_mode && !sts.empty) begin
            // peek next root before deciding on last
            state_next = S_HOLD;
            cmd.out_load = 1'b0;
            cmd.set_cur_root = 1'b1;
            cmd.rd_at_cur = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_HOLD: begin
        // root data now read: emit removed entry with last flag
        cmd.out_load = 1'b1;
        cmd.res_last = !sts.root_due;
        in_rm_next = 1'b0;
        state_next = sts.root_due ? S_RM_START : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // Input is only taken when idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  // Datapath commands are never combined in conflicting ways
  a_move_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.move_parent, cmd.move_child, cmd.place, cmd.rm_take}))
    else $error("conflicting heap writes");
  // A load of the input is followed by a decode
  a_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state == S_DECODE) else $error("no decode after load");
`endif
endmodule

/* hw/rtl/tmhq_dp.sv */
// Datapath of the timer min-heap queue: heap memories, id table, live bits,
// free list, counters and the output register. Depends on tmhq_pkg.
module tmhq_dp #(
  parameter int unsigned CAPACITY = tmhq_pkg::CapacityDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          in_action,
  input  logic [63:0]         in_due_time,
  input  logic [7:0]          in_timer_id,
  input  logic [63:0]         in_now,
  input  tmhq_pkg::tmhq_cmd_t cmd,
  output tmhq_pkg::tmhq_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [5:0]          out_timer_id,
  output logic [63:0]         out_time_value,
  output logic [6:0]          out_active_count,
  output logic                out_last
);
  import tmhq_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);  // index width
  localparam int unsigned CW = IW + 1;            // count width

  // Memories
  logic [TimeW-1:0] heap_time [CAPACITY];
  logic [IW-1:0]    heap_owner_id [CAPACITY];
  logic [CW-1:0]    slot_of_id [CAPACITY];
  logic [CAPACITY-1:0] id_live;

  logic [2:0]       action;
  logic [TimeW-1:0] due_time, now;
  logic [7:0]       req_id;
  logic [CW-1:0]    free_head, entry_count, init_cnt;
  logic [IW-1:0]    cur;
  logic [IW-1:0]    mv_id;
  logic [TimeW-1:0] mv_time;
  logic [CW-1:0]    link_rd;
  logic [TimeW-1:0] rd_time_a, rd_time_b;
  logic [IW-1:0]    rd_id_a, rd_id_b;
  logic [2:0]       res_st;
  logic [IW-1:0]    res_id;
  logic [TimeW-1:0] res_time;
  logic             rd_b_valid;

  // Derived addresses
  logic [CW:0] child_a;
  logic [IW-1:0] parent;
  assign parent  = (cur - IW'(1)) >> 1;
  assign child_a = {1'b0, cur, 1'b1};

  logic b_smaller;
  assign b_smaller = rd_b_valid && (rd_time_b < rd_time_a);

  // Status
  always_comb begin
    sts.action = action;
    sts.free_full = (free_head >= CW'(CAPACITY)) || (entry_count >= CW'(CAPACITY));
    sts.id_range = 32'(req_id) >= CAPACITY;
    sts.id_live = id_live[IW'(req_id)];
    sts.empty = entry_count == '0;
    sts.root_due = rd_time_a <= now;
    sts.init_done = init_cnt == CW'(CAPACITY - 1);
    sts.cur_zero = cur == '0;
    sts.moved_lt_parent = mv_time < rd_time_a;
    // entry_count still holds the count before the removal
    sts.hole_valid = {1'b0, cur} < (entry_count - CW'(1));
    sts.has_child = child_a < {1'b0, entry_count};
    sts.child_lt = (b_smaller ? rd_time_b : rd_time_a) < mv_time;
    sts.out_busy = out_valid && !out_ready;
  end

  // Heap memory: reads registered, one write port
  always_ff @(posedge clk) begin
    rd_b_valid <= cmd.rd_children && ((child_a + 1'b1) < {1'b0, entry_count});
    if (cmd.rd_at_cur) begin
      // a root peek is issued while cur is being reset to the root
      rd_time_a <= heap_time[cmd.set_cur_root ? '0 : cur];
      rd_id_a   <= heap_owner_id[cmd.set_cur_root ? '0 : cur];
    end else if (cmd.rd_last) begin
      rd_time_b <= heap_time[IW'(entry_count - CW'(1))];
      rd_id_b   <= heap_owner_id[IW'(entry_count - CW'(1))];
      rd_time_a <= rd_time_a;
      rd_id_a   <= rd_id_a;
    end else if (cmd.rd_parent) begin
      rd_time_a <= heap_time[parent];
      rd_id_a   <= heap_owner_id[parent];
    end else if (cmd.rd_children) begin
      rd_time_a <= heap_time[IW'(child_a)];
      rd_id_a   <= heap_owner_id[IW'(child_a)];
      rd_time_b <= heap_time[IW'(child_a + 1'b1)];
      rd_id_b   <= heap_owner_id[IW'(child_a + 1'b1)];
    end
    if (cmd.move_parent) begin
      heap_time[cur] <= rd_time_a;
      heap_owner_id[cur] <= rd_id_a;
    end else if (cmd.move_child) begin
      heap_time[cur] <= b_smaller ? rd_time_b : rd_time_a;
      heap_owner_id[cur] <= b_smaller ? rd_id_b : rd_id_a;
    end else if (cmd.place) begin
      heap_time[cur] <= mv_time;
      heap_owner_id[cur] <= mv_id;
    end
  end

  // Id table: link chain at init, slot or free link afterwards
  always_ff @(posedge clk) begin
    if (cmd.rd_link) link_rd <= slot_of_id[action == ACT_SCHEDULE ? IW'(free_head) :
                                                                    IW'(req_id)];
    if (cmd.init_wr) slot_of_id[IW'(init_cnt)] <= init_cnt + CW'(1);
    else if (cmd.rm_take) slot_of_id[rd_id_a] <= free_head;
    else if (cmd.move_parent) slot_of_id[rd_id_a] <= {1'b0, cur};
    else if (cmd.move_child) slot_of_id[b_smaller ? rd_id_b : rd_id_a] <= {1'b0, cur};
    else if (cmd.place) slot_of_id[mv_id] <= {1'b0, cur};
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
      free_head <= CW'(1);
      entry_count <= '0;
      id_live <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.init_wr && !sts.init_done) init_cnt <= init_cnt + CW'(1);
      if (cmd.sched_take) begin
        free_head <= link_rd;
        id_live[IW'(free_head)] <= 1'b1;
      end
      if (cmd.cnt_inc) entry_count <= entry_count + CW'(1);
      if (cmd.rm_take) begin
        free_head <= {1'b0, rd_id_a};
        id_live[rd_id_a] <= 1'b0;
        entry_count <= entry_count - CW'(1);
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action <= in_action;
      due_time <= in_due_time;
      req_id <= in_timer_id;
      now <= in_now;
      res_st <= ST_OK;
      res_id <= '0;
      res_time <= '0;
    end
    if (cmd.st != ST_OK) res_st <= cmd.st;
    if (cmd.res_id_only) res_id <= IW'(req_id);
    if (cmd.res_from_look) begin
      res_id <= IW'(req_id);
      res_time <= rd_time_a;
    end
    if (cmd.res_sched) begin
      res_id <= IW'(free_head);
      res_time <= due_time;
    end
    if (cmd.res_from_rd) begin
      res_id <= rd_id_a;
      res_time <= rd_time_a;
    end
    if (cmd.set_cur_root) cur <= '0;
    else if (cmd.set_cur_link) cur <= IW'(link_rd);
    else if (cmd.sched_take) cur <= IW'(entry_count);
    else if (cmd.move_parent) cur <= parent;
    else if (cmd.move_child) cur <= b_smaller ? IW'(child_a + 1'b1) : IW'(child_a);
    if (cmd.sched_take) begin
      mv_id <= IW'(free_head);
      mv_time <= due_time;
    end
    if (cmd.rm_take) begin
      mv_id <= rd_id_b;
      mv_time <= rd_time_b;
    end
    if (cmd.out_load) begin
      out_status <= res_st;
      out_timer_id <= 6'(res_id);
      out_time_value <= res_time;
      out_active_count <= 7'(entry_count);
      out_last <= cmd.res_last;
    end
  end

`ifndef SYNTHESIS
  // Heap never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY)) else $error("count overflow");
  // Id 0 is never live
  a_id0: assert property (@(posedge clk) disable iff (rst)
    !id_live[0]) else $error("id 0 live");
  // Output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("beat dropped");
`endif
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for timer_min_heap_queue_unit: a behavioral min-heap
// predictor checks every result beat. Depends on tmhq_pkg and the block RTL.
module tb_top;
  import tmhq_pkg::*;

  localparam int Cap = 64;
  localparam longint CycleLimit = 2000000;

  typedef struct packed {
    logic [2:0]  st;
    logic [5:0]  id;
    logic [63:0] tv;
    logic [6:0]  cnt;
    logic        lst;
  } timer_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic m_axis_tlast;

  timer_min_heap_queue_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: heap of due times, owner ids, id to slot/link table
  logic [63:0] hp_time [Cap];
  int unsigned hp_owner [Cap];
  int unsigned id_slot [Cap];
  bit id_busy [Cap];
  int unsigned free_top, heap_cnt;
  timer_res_t due_results[$];

  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_off = 0;
  int mism = 0;
  longint cycles = 0;

  function automatic void put_entry(int unsigned i, int unsigned id, logic [63:0] t);
    hp_time[i] = t;
    hp_owner[i] = id;
    id_slot[id] = i;
  endfunction

  function automatic void bubble_up(int unsigned id, logic [63:0] t, int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (t < hp_time[p]) begin
        put_entry(i, hp_owner[p], hp_time[p]);
        i = p;
      end else break;
    end
    put_entry(i, id, t);
  endfunction

  function automatic void bubble_down(int unsigned id, logic [63:0] t, int unsigned i);
    int unsigned c;
    c = 2 * i + 1;
    while (c < heap_cnt) begin
      if (c + 1 < heap_cnt && hp_time[c+1] < hp_time[c]) c++;
      if (hp_time[c] < t) begin
        put_entry(i, hp_owner[c], hp_time[c]);
        i = c;
        c = 2 * c + 1;
      end else break;
    end
    put_entry(i, id, t);
  endfunction

  function automatic void take_out(int unsigned i, output int unsigned id,
                                   output logic [63:0] t);
    int unsigned mid, p;
    logic [63:0] mt;
    id = hp_owner[i];
    t = hp_time[i];
    id_slot[id] = free_top;
    id_busy[id] = 1'b0;
    free_top = id;
    heap_cnt--;
    if (i < heap_cnt) begin
      mid = hp_owner[heap_cnt];
      mt = hp_time[heap_cnt];
      p = (i != 0) ? (i - 1) / 2 : 0;
      put_entry(i, mid, mt);
      if (mt >= hp_time[p]) bubble_down(mid, mt, i);
      else bubble_up(mid, mt, i);
    end
  endfunction

  function automatic void push_res(status_t st, int unsigned id, logic [63:0] t,
                                   bit lst);
    timer_res_t r;
    r.st = st;
    r.id = id[5:0];
    r.tv = t;
    r.cnt = heap_cnt[6:0];
    r.lst = lst;
    due_results.push_back(r);
  endfunction

  function automatic void predict_op(logic [2:0] act, logic [63:0] due,
                                     logic [7:0] tid, logic [63:0] now);
    int unsigned id;
    logic [63:0] t;
    case (act) inside
      ACT_SCHEDULE: begin
        if (free_top >= Cap || heap_cnt >= Cap) push_res(ST_FULL, 0, 0, 1);
        else begin
          id = free_top;
          free_top = id_slot[id];
          id_busy[id] = 1'b1;
          bubble_up(id, due, heap_cnt);
          heap_cnt++;
          push_res(ST_OK, id, due, 1);
        end
      end
      ACT_CANCEL, ACT_QUERY: begin
        if (tid >= Cap) push_res(ST_RANGE, 0, 0, 1);
        else if (!id_busy[tid]) push_res(ST_INACTIVE, tid, 0, 1);
        else begin
          id = tid;
          if (act == ACT_CANCEL) take_out(id_slot[id], id, t);
          else t = hp_time[id_slot[id]];
          push_res(ST_OK, id, t, 1);
        end
      end
      ACT_EXPIRE: begin
        if (heap_cnt == 0 || hp_time[0] > now) push_res(ST_NONE_DUE, 0, 0, 1);
        else
          while (heap_cnt > 0 && hp_time[0] <= now) begin
            take_out(0, id, t);
            push_res(ST_OK, id, t, !(heap_cnt > 0 && hp_time[0] <= now));
          end
      end
      ACT_CLEAR: begin
        while (heap_cnt > 0) take_out(0, id, t);
        push_res(ST_OK, 0, 0, 1);
      end
      default: push_res(ST_OK, 0, 0, 1);
    endcase
  endfunction

  // Send one beat; prediction happens when it is accepted
  task automatic send_op(logic [2:0] act, logic [63:0] due, logic [7:0] tid,
                         logic [63:0] now);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, now, tid, due, act};
    do @(posedge clk); while (!s_axis_tready);
    predict_op(act, due, tid, now);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    timer_res_t exp_r, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[2:0], m_axis_tdata[8:3], m_axis_tdata[72:9],
             m_axis_tdata[79:73], m_axis_tlast};
      if (due_results.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_r = due_results.pop_front();
        if (got !== exp_r) begin
          mism++;
          if (mism <= 10)
            $display({"mismatch: exp st=%0d id=%0d t=%h cnt=%0d last=%0b",
                      " | got st=%0d id=%0d t=%h cnt=%0d last=%0b"},
                     exp_r.st, exp_r.id, exp_r.tv, exp_r.cnt, exp_r.lst,
                     got.st, got.id, got.tv, got.cnt, got.lst);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Extremes of every field and every special case
  task automatic test_directed();
    send_op(ACT_EXPIRE, 0, 0, '1);            // empty heap: none due
    send_op(ACT_QUERY, 0, 8'd0, 0);           // id 0 never live
    send_op(ACT_CANCEL, 0, 8'd255, 0);        // out of range
    send_op(ACT_QUERY, 0, 8'd64, 0);          // just out of range
    send_op(ACT_SCHEDULE, '1, 0, 0);
    send_op(ACT_SCHEDULE, 64'd0, 0, 0);
    send_op(ACT_SCHEDULE, 64'd50, 0, 0);
    send_op(ACT_SCHEDULE, 64'd50, 0, 0);      // equal due times
    send_op(ACT_SCHEDULE, 64'd10, 0, 0);
    send_op(ACT_QUERY, 0, 8'd1, 0);
    send_op(ACT_QUERY, 0, 8'd63, 0);
    send_op(ACT_CANCEL, 0, 8'd2, 0);
    send_op(ACT_CANCEL, 0, 8'd2, 0);          // now inactive
    send_op(ACT_EXPIRE, 0, 0, 64'd0);
    send_op(ACT_EXPIRE, 0, 0, 64'd5);         // earliest not yet due
    send_op(ACT_EXPIRE, 0, 0, 64'd60);
    send_op(3'd5, '1, '1, '1);                // unknown actions
    send_op(3'd7, 0, 0, 0);
    send_op(3'd6, 0, 0, 0);
    send_op(ACT_CLEAR, 0, 0, 0);
    send_op(ACT_EXPIRE, 0, 0, '1);
  endtask

  // Fill to full with the receiver held off, then expire all at once
  task automatic test_full_and_backpressure();
    hold_off = 400;
    for (int i = 0; i < 66; i++) send_op(ACT_SCHEDULE, rand64(), 0, 0);
    wait_drained();
    send_op(ACT_CANCEL, 0, 8'd63, 0);
    send_op(ACT_CANCEL, 0, 8'd7, 0);
    send_op(ACT_SCHEDULE, 64'd3, 0, 0);
    send_op(ACT_EXPIRE, 0, 0, '1);            // long burst of results
    wait_drained();
  endtask

  // Random mix: mostly schedules, cancels, queries and expires, small times, in-range ids
  task automatic test_random(int n);
    logic [2:0] act;
    logic [63:0] t;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) act = ACT_SCHEDULE;
      else if (r < 55) act = ACT_CANCEL;
      else if (r < 70) act = ACT_QUERY;
      else if (r < 92) act = ACT_EXPIRE;
      else if (r < 95) act = ACT_CLEAR;
      else act = 3'($urandom_range(7));
      t = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(1000));
      send_op(act, t,
              ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(Cap - 1)),
              ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(1000)));
      if (i == n / 2) wait_drained();     // sender pauses until all is back
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < Cap; i++) begin
      id_slot[i] = i + 1;
      id_busy[i] = 1'b0;
    end
    free_top = 1;
    heap_cnt = 0;
    test_directed();
    test_full_and_backpressure();
    send_idle_pct = 18;
    recv_idle_pct = 71;
    test_random(60);
    send_idle_pct = 71;
    recv_idle_pct = 18;
    test_random(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(80);
    wait_drained();
    if (mism == 0 && due_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
